FILE: hdl/windowed_mean_outlier_reject_unit_assert.svh
// Assertion macros shared by the outlier reject unit
`ifndef WINDOWED_MEAN_OUTLIER_REJECT_UNIT_ASSERT_SVH
`define WINDOWED_MEAN_OUTLIER_REJECT_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define WMOR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define WMOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wmor_pkg.sv
// Shared constants and controller/datapath bundle types for the outlier reject unit
package wmor_pkg;

    localparam int MAX_DIM_DEF      = 64;
    localparam int MAX_RADIUS_DEF   = 7;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int COORD_W    = 6;
    localparam int GRID_W     = 7;
    localparam int RAD_W      = 3;
    localparam int MINC_W     = 8;
    localparam int THR_W      = 16;
    localparam int VCNT_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

    localparam logic [GRID_W-1:0] GRID_W_RST    = 7'd64;
    localparam logic [GRID_W-1:0] GRID_H_RST    = 7'd64;
    localparam logic [RAD_W-1:0]  RADIUS_RST    = 3'd1;
    localparam logic [MINC_W-1:0] MIN_COUNT_RST = 8'd1;
    localparam logic [THR_W-1:0]  THRESH_RST    = 16'd0;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic load_wr;
        logic cap_item;
        logic start;
        logic walk;
        logic cap_center;
        logic do_mul;
        logic do_cmp;
        logic zero_res;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic in_grid;
        logic clr_last;
        logic ctr_present;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/wmor_in_if.sv
// Request channel carrying load and evaluate items
interface wmor_in_if
    import wmor_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    sample_valid;

    modport source (output valid, mode, col, row, sample, sample_valid, input ready);
    modport sink   (input valid, mode, col, row, sample, sample_valid, output ready);
endinterface

FILE: hdl/wmor_out_if.sv
// Result channel carrying one filtered cell per evaluate request
interface wmor_out_if
    import wmor_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] result_sample;
    logic                    result_valid;
    logic [VCNT_W-1:0]       valid_count;

    modport source (output valid, result_sample, result_valid, valid_count, input ready);
    modport sink   (input valid, result_sample, result_valid, valid_count, output ready);
endinterface

FILE: hdl/wmor_dp.sv
// Datapath: config registers, cell store, window walker, accumulator, mean test, output register
module wmor_dp
    import wmor_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_valid,
    input  logic                    i_mode,
    input  logic [COORD_W-1:0]      i_col,
    input  logic [COORD_W-1:0]      i_row,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_sample_valid,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [SAMPLE_WIDTH-1:0] o_result_sample,
    output logic                    o_result_valid,
    output logic [VCNT_W-1:0]       o_valid_count,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts
);
    localparam int SW      = SAMPLE_WIDTH;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int FW      = AW + GRID_W;
    localparam int DIM_CAP = (MAX_DIM < 127) ? MAX_DIM : 127;
    localparam int RAD_CAP = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
    localparam int CNT_W   = $clog2((2 * RAD_CAP + 1) * (2 * RAD_CAP + 1) + 1);
    localparam int SUM_W   = SW + CNT_W;
    localparam int DW      = ((SW > THR_W) ? SW : THR_W) + CNT_W + 2;

    // configuration
    logic [GRID_W-1:0] r_grid_w, r_grid_h;
    logic [RAD_W-1:0]  r_radius;
    logic [MINC_W-1:0] r_min_cnt;
    logic [THR_W-1:0]  r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w  <= GRID_W_RST;
            r_grid_h  <= GRID_H_RST;
            r_radius  <= RADIUS_RST;
            r_min_cnt <= MIN_COUNT_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_w  <= i_cfg_wdata[GRID_W-1:0];
                CFG_GRID_HEIGHT: r_grid_h  <= i_cfg_wdata[GRID_W-1:0];
                CFG_RADIUS:      r_radius  <= i_cfg_wdata[RAD_W-1:0];
                CFG_MIN_COUNT:   r_min_cnt <= i_cfg_wdata[MINC_W-1:0];
                CFG_THRESHOLD:   r_thresh  <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated working config
    logic [GRID_W-1:0] w_c, h_c;
    logic [RAD_W-1:0]  rad_c;

    always_comb begin
        if (r_grid_w == '0) w_c = GRID_W'(1);
        else if (r_grid_w > GRID_W'(DIM_CAP)) w_c = GRID_W'(DIM_CAP);
        else w_c = r_grid_w;
        if (r_grid_h == '0) h_c = GRID_W'(1);
        else if (r_grid_h > GRID_W'(DIM_CAP)) h_c = GRID_W'(DIM_CAP);
        else h_c = r_grid_h;
        rad_c = (r_radius > RAD_W'(RAD_CAP)) ? RAD_W'(RAD_CAP) : r_radius;
    end

    function automatic logic [AW-1:0] f_addr(input logic [GRID_W-1:0] rr,
                                             input logic [GRID_W-1:0] cc);
        logic [FW-1:0] full;
        full = FW'(rr) * FW'(MAX_DIM) + FW'(cc);
        return full[AW-1:0];
    endfunction

    // item coordinates
    logic [GRID_W-1:0] in_col, in_row;
    logic              in_store;
    assign in_col   = {1'b0, i_col};
    assign in_row   = {1'b0, i_row};
    assign in_store = (in_col < GRID_W'(DIM_CAP)) && (in_row < GRID_W'(DIM_CAP));

    logic [GRID_W-1:0] r_col, r_row;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_col <= in_col;
            r_row <= in_row;
        end
    end

    // window bounds, clipped to the grid
    logic [GRID_W-1:0] c0_n, c1_n, r0_n, r1_n, cmax_t, rmax_t, wl, hl;
    always_comb begin
        wl     = w_c - GRID_W'(1);
        hl     = h_c - GRID_W'(1);
        c0_n   = (r_col > GRID_W'(rad_c)) ? r_col - GRID_W'(rad_c) : '0;
        r0_n   = (r_row > GRID_W'(rad_c)) ? r_row - GRID_W'(rad_c) : '0;
        cmax_t = r_col + GRID_W'(rad_c);
        rmax_t = r_row + GRID_W'(rad_c);
        c1_n   = (cmax_t < wl) ? cmax_t : wl;
        r1_n   = (rmax_t < hl) ? rmax_t : hl;
    end

    logic [GRID_W-1:0] r_c0, r_c1, r_r1, r_cc, r_rr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_c0 <= c0_n;
            r_c1 <= c1_n;
            r_r1 <= r1_n;
            r_cc <= c0_n;
            r_rr <= r0_n;
        end else if (i_cmd.walk) begin
            if (r_cc == r_c1) begin
                r_cc <= r_c0;
                r_rr <= r_rr + GRID_W'(1);
            end else begin
                r_cc <= r_cc + GRID_W'(1);
            end
        end
    end

    // cell store: {present, value}; clearing sweep after reset wipes the present marks
    logic [SW:0]    r_mem [DEPTH];
    logic [SW:0]    r_rd_data;
    logic [AW-1:0]  r_clr_addr;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [SW:0]    wr_data;
    logic           wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + AW'(1);
    end

    always_comb begin
        wr_en   = i_cmd.clr_wr || (i_cmd.load_wr && in_store);
        wr_addr = i_cmd.clr_wr ? r_clr_addr : f_addr(in_row, in_col);
        wr_data = i_cmd.clr_wr ? '0 : {i_sample_valid, i_sample};
        rd_addr = i_cmd.start ? f_addr(r_row, r_col) : f_addr(r_rr, r_cc);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd_data <= r_mem[rd_addr];
    end

    // accumulate present samples in the cycle after each walk read
    logic                    r_pend;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SW-1:0]    r_v;
    logic signed [SW-1:0]    rd_val;
    assign rd_val = r_rd_data[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else r_pend <= i_cmd.walk;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else if (r_pend && r_rd_data[SW]) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_sum <= r_sum + SUM_W'(rd_val);
        end
        if (i_cmd.cap_center) r_v <= rd_val;
    end

    // mean test: count >= min count and |v*count - sum| <= thr*count
    logic signed [DW-1:0] r_vc;
    logic [DW-1:0]        r_lim;
    logic signed [DW-1:0] v_ext, c_ext, diff;
    logic [DW-1:0]        abs_diff;
    logic                 pass;

    always_comb begin
        v_ext    = DW'(r_v);
        c_ext    = DW'({1'b0, r_cnt});
        diff     = r_vc - DW'(r_sum);
        abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
        pass     = (VCNT_W'(r_cnt) >= r_min_cnt) && (abs_diff <= r_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_mul) begin
            r_vc  <= v_ext * c_ext;
            r_lim <= DW'(r_thresh) * DW'(r_cnt);
        end
    end

    logic [SW-1:0]     r_res_sample;
    logic              r_res_valid;
    logic [VCNT_W-1:0] r_res_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_res) begin
            r_res_sample <= '0;
            r_res_valid  <= 1'b0;
            r_res_cnt    <= '0;
        end else if (i_cmd.do_cmp) begin
            r_res_sample <= pass ? r_v : '0;
            r_res_valid  <= pass;
            r_res_cnt    <= VCNT_W'(r_cnt);
        end
    end

    // output register
    logic r_out_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_sample <= r_res_sample;
            o_result_valid  <= r_res_valid;
            o_valid_count   <= r_res_cnt;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.in_valid    = i_valid;
        o_sts.in_mode     = i_mode;
        o_sts.in_grid     = (in_col < w_c) && (in_row < h_c);
        o_sts.clr_last    = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.ctr_present = r_rd_data[SW];
        o_sts.walk_last   = (r_cc == r_c1) && (r_rr == r_r1);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

FILE: hdl/wmor_ctrl.sv
// Controller state machine: clearing sweep, request intake, window walk sequencing
module wmor_ctrl
    import wmor_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CCHK  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_mode == MODE_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.cap_item = 1'b1;
                        if (i_sts.in_grid) begin
                            n_state = S_CRD;
                        end else begin
                            o_cmd.zero_res = 1'b1;
                            n_state        = S_DONE;
                        end
                    end
                end
            end
            S_CRD: begin
                o_cmd.start = 1'b1;
                n_state     = S_CCHK;
            end
            S_CCHK: begin
                o_cmd.cap_center = 1'b1;
                if (i_sts.ctr_present) begin
                    n_state = S_WALK;
                end else begin
                    // missing cell stays missing, no walk
                    o_cmd.zero_res = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_MUL;
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.do_cmp = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/windowed_mean_outlier_reject_unit.sv
// Top level of the windowed mean outlier reject unit
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    mode, col, row, sample, sample_valid
//  o_out     out  valid/ready    result_sample, result_valid, valid_count
//  i_cfg_*   in   write enable   register index, write data
//
// Load request: written straight into the cell store.
// Evaluate request: the walk reads the cell store one window cell per cycle; a cell
// outside the grid or a missing centre cell skips the walk and gives a zero result.
// After reset a clearing sweep over all MAX_DIM*MAX_DIM entries (4096) wipes the present marks;
// no request is taken meanwhile. A result waits in the output register without stalling
// loads; the next evaluate holds in its last cycle until that register frees.
module windowed_mean_outlier_reject_unit
    import wmor_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_RADIUS   = MAX_RADIUS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    wmor_in_if.sink               i_in,
    wmor_out_if.source            o_out
);
    `include "windowed_mean_outlier_reject_unit_assert.svh"

    t_cmd cmd;
    t_sts sts;

    assign i_in.ready = cmd.in_ready;

    wmor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wmor_dp #(
        .MAX_DIM      (MAX_DIM),
        .MAX_RADIUS   (MAX_RADIUS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_in.valid),
        .i_mode          (i_in.mode),
        .i_col           (i_in.col),
        .i_row           (i_in.row),
        .i_sample        (i_in.sample),
        .i_sample_valid  (i_in.sample_valid),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_result_sample (o_out.result_sample),
        .o_result_valid  (o_out.result_valid),
        .o_valid_count   (o_out.valid_count),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

    `WMOR_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, cmd.out_load, sts.out_free, "result loaded over an untaken one")
    `WMOR_ASSERT_NEXT(a_eval_blocks, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.mode == MODE_EVAL), !i_in.ready, "request taken during an evaluate")
    `WMOR_ASSERT_SAME(a_out_from_load, i_clk, i_rst_n, $rose(o_out.valid), $past(cmd.out_load), "result valid without a load")

endmodule

FILE: test/tb_windowed_mean_outlier_reject_unit.sv
// Testbench for the windowed mean outlier reject unit: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module tb_windowed_mean_outlier_reject_unit
    import wmor_pkg::*;
();

    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 20000;  // covers the clearing sweep and the long output stall
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES  = 250;
    localparam int HOLD_CYCLES  = 800;
    localparam int CELLS        = MAX_DIM_DEF * MAX_DIM_DEF;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [15:0]        sample;
        logic               present;
    } t_cell_req;

    typedef struct packed {
        logic [15:0]       smp;
        logic              kept;
        logic [VCNT_W-1:0] nvalid;
    } t_filt_res;

    typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic [15:0]           sample;
        logic                  present;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  typed;
        logic [15:0]           t_smp;
        logic                  t_kept;
        logic [VCNT_W-1:0]     t_nvalid;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    // kind, col, row, sample, present, reg, value, typed, kept sample, kept, count
    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_EVAL, 6'd0,  6'd0,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd63, 6'd63, 16'h0000, 1'b0, '0, '0, 1'b1, 16'h0000, 1'b0, 8'd0},
        '{ROW_LOAD, 6'd5,  6'd5,  16'h7FFF, 1'b1, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h7FFF, 1'b1, 8'd1},
        '{ROW_LOAD, 6'd6,  6'd5,  16'h8000, 1'b1, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        // most positive next to most negative: far from the mean at zero threshold
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h0000, 1'b0, 8'd2},
        '{ROW_EVAL, 6'd6,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        // missing load clears the mark
        '{ROW_LOAD, 6'd6,  6'd5,  16'h8000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd6,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h7FFF, 1'b1, 8'd1},
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_THRESHOLD, 16'hFFFF,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_LOAD, 6'd6,  6'd5,  16'h8000, 1'b1, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        // width zero saturates to one column
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_GRID_WIDTH, 16'd0,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b1, 16'h0000, 1'b0, 8'd0},
        '{ROW_LOAD, 6'd0,  6'd0,  16'd123,  1'b1, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd0,  6'd0,  16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        // width above the store saturates to full size
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_GRID_WIDTH, 16'd100,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_RADIUS, 16'd7,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_MIN_COUNT, 16'd255,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd5,  6'd5,  16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_MIN_COUNT, 16'd0,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_LOAD, 6'd63, 6'd63, 16'hFFFF, 1'b1, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd63, 6'd63, 16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_CFG,  6'd0,  6'd0,  16'h0000, 1'b0, CFG_GRID_HEIGHT, 16'd0,
          1'b0, 16'h0000, 1'b0, 8'd0},
        '{ROW_EVAL, 6'd0,  6'd0,  16'h0000, 1'b0, '0, '0, 1'b0, 16'h0000, 1'b0, 8'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wmor_in_if  in_ch ();
    wmor_out_if out_ch ();

    windowed_mean_outlier_reject_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state
    logic [15:0]       cell_val [CELLS];
    bit                cell_pres [CELLS];
    bit [GRID_W-1:0]   cur_w    = GRID_W_RST;
    bit [GRID_W-1:0]   cur_h    = GRID_H_RST;
    bit [RAD_W-1:0]    cur_rad  = RADIUS_RST;
    bit [MINC_W-1:0]   cur_minc = MIN_COUNT_RST;
    bit [THR_W-1:0]    cur_thr  = THRESH_RST;

    t_filt_res filtered_q [$];

    int  errors     = 0;
    int  n_loads    = 0;
    int  n_evals    = 0;
    int  n_results  = 0;
    int  n_kept     = 0;
    int  n_settings = 0;
    int  idle_run   = 0;
    int  rx_hold    = 0;
    bit  rush       = 1'b0;

    // focus region and sample spread of the current phase
    int          reg_x0, reg_y0, reg_w, reg_h;
    logic [15:0] ph_base;
    int          ph_spread;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int fit_dim(input int d);
        if (d < 1)
            return 1;
        if (d > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return d;
    endfunction

    function automatic t_filt_res filter_cell(input t_cell_req r);
        t_filt_res res;
        int        w, h, rad, cx, cy, a, c0, c1, r0, r1, n;
        longint    v, acc, diff;
        res = '0;
        w   = fit_dim(cur_w);
        h   = fit_dim(cur_h);
        rad = (cur_rad > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : cur_rad;
        cx  = r.col;
        cy  = r.row;
        if (cx >= w || cy >= h)
            return res;
        a = cy * MAX_DIM_DEF + cx;
        if (!cell_pres[a])
            return res;
        v  = longint'($signed(cell_val[a]));
        c0 = (cx > rad) ? cx - rad : 0;
        c1 = (cx + rad < w - 1) ? cx + rad : w - 1;
        r0 = (cy > rad) ? cy - rad : 0;
        r1 = (cy + rad < h - 1) ? cy + rad : h - 1;
        n   = 0;
        acc = 0;
        for (int y = r0; y <= r1; y++) begin
            for (int x = c0; x <= c1; x++) begin
                if (cell_pres[y * MAX_DIM_DEF + x]) begin
                    n++;
                    acc += longint'($signed(cell_val[y * MAX_DIM_DEF + x]));
                end
            end
        end
        res.nvalid = VCNT_W'(n);
        if (n >= int'(cur_minc)) begin
            // distance to mean, scaled by count to avoid division
            diff = v * n - acc;
            if (diff < 0)
                diff = -diff;
            if (diff <= longint'(cur_thr) * n) begin
                res.smp  = cell_val[a];
                res.kept = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic push_request(input t_cell_req r, input bit typed, input t_filt_res typed_res);
        int a;
        @(negedge clk);
        while (!rush && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= r.mode;
        in_ch.col          <= r.col;
        in_ch.row          <= r.row;
        in_ch.sample       <= r.sample;
        in_ch.sample_valid <= r.present;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        if (r.mode == MODE_LOAD) begin
            a = int'(r.row) * MAX_DIM_DEF + int'(r.col);
            cell_val[a]  = r.sample;
            cell_pres[a] = r.present;
            n_loads++;
        end else begin
            filtered_q.push_back(typed ? typed_res : filter_cell(r));
            n_evals++;
        end
    endtask

    // drop valid, then let every pending result and any trailing load finish
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_GRID_WIDTH:  cur_w    = val[GRID_W-1:0];
            CFG_GRID_HEIGHT: cur_h    = val[GRID_W-1:0];
            CFG_RADIUS:      cur_rad  = val[RAD_W-1:0];
            CFG_MIN_COUNT:   cur_minc = val[MINC_W-1:0];
            CFG_THRESHOLD:   cur_thr  = val[THR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int extreme_dim();
        case ($urandom_range(4))
            0: return 0;
            1: return 1;
            2: return MAX_DIM_DEF;
            3: return 100;
            default: return 127;
        endcase
    endfunction

    task automatic start_phase();
        int pick, gw, gh, thr, minc;
        wait_drained();
        pick = $urandom_range(9);
        if (pick == 0) begin
            gw = MAX_DIM_DEF;
            gh = MAX_DIM_DEF;
        end else if (pick == 1) begin
            gw = extreme_dim();
            gh = extreme_dim();
        end else begin
            gw = $urandom_range(2, 10);
            gh = $urandom_range(2, 10);
        end
        case ($urandom_range(3))
            0: ph_spread = 0;
            1: ph_spread = 15;
            2: ph_spread = 400;
            default: ph_spread = 65535;
        endcase
        ph_base = 16'($urandom_range(65535));
        pick = $urandom_range(9);
        if (pick == 0)
            thr = 0;
        else if (pick == 1)
            thr = 65535;
        else if (pick < 4)
            thr = $urandom_range(65535);
        else
            thr = $urandom_range(ph_spread);
        pick = $urandom_range(19);
        if (pick < 3)
            minc = 0;
        else if (pick == 3)
            minc = ($urandom_range(1) != 0) ? 225 : 255;
        else
            minc = $urandom_range(1, 9);
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(gw));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(gh));
        write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(MAX_RADIUS_DEF)));
        write_reg(CFG_MIN_COUNT, CFG_DATA_W'(minc));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        n_settings++;
        reg_w  = (fit_dim(gw) < 8) ? fit_dim(gw) : 8;
        reg_h  = (fit_dim(gh) < 8) ? fit_dim(gh) : 8;
        reg_x0 = $urandom_range(fit_dim(gw) - reg_w);
        reg_y0 = $urandom_range(fit_dim(gh) - reg_h);
    endtask

    // mostly loads and evaluates clustered in the phase's region, some anywhere
    function automatic t_cell_req random_request();
        t_cell_req r;
        r.mode = ($urandom_range(99) < 58) ? MODE_LOAD : MODE_EVAL;
        if ($urandom_range(99) < 88) begin
            r.col = COORD_W'(reg_x0 + $urandom_range(reg_w - 1));
            r.row = COORD_W'(reg_y0 + $urandom_range(reg_h - 1));
        end else begin
            r.col = COORD_W'($urandom_range(MAX_DIM_DEF - 1));
            r.row = COORD_W'($urandom_range(MAX_DIM_DEF - 1));
        end
        if ($urandom_range(99) < 8)
            r.sample = 16'($urandom_range(65535));
        else
            r.sample = ph_base + 16'($urandom_range(ph_spread));
        r.present = ($urandom_range(99) < 85);
        return r;
    endfunction

    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= rush || ($urandom_range(99) >= 32);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_filt_res exp_res;
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                idle_run = 0;
            else
                idle_run++;
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (filtered_q.size() == 0) begin
                    $error("result with no evaluate request pending");
                    errors++;
                end else begin
                    exp_res = filtered_q.pop_front();
                    n_results++;
                    if (out_ch.result_valid === 1'b1)
                        n_kept++;
                    if (out_ch.result_sample !== exp_res.smp) begin
                        $error("result_sample: expected %0d, got %0d",
                               $signed(exp_res.smp), $signed(out_ch.result_sample));
                        errors++;
                    end
                    if (out_ch.result_valid !== exp_res.kept) begin
                        $error("result_valid: expected %0b, got %0b",
                               exp_res.kept, out_ch.result_valid);
                        errors++;
                    end
                    if (out_ch.valid_count !== exp_res.nvalid) begin
                        $error("valid_count: expected %0d, got %0d",
                               exp_res.nvalid, out_ch.valid_count);
                        errors++;
                    end
                end
            end
            if (idle_run >= IDLE_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_cell_req req;
        t_filt_res tres;
        int        n_random;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_LOAD;
        in_ch.col          = '0;
        in_ch.row          = '0;
        in_ch.sample       = '0;
        in_ch.sample_valid = 1'b0;
        n_random           = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                req.mode    = (dir_tab[i].kind == ROW_LOAD) ? MODE_LOAD : MODE_EVAL;
                req.col     = dir_tab[i].col;
                req.row     = dir_tab[i].row;
                req.sample  = dir_tab[i].sample;
                req.present = dir_tab[i].present;
                tres.smp    = dir_tab[i].t_smp;
                tres.kept   = dir_tab[i].t_kept;
                tres.nvalid = dir_tab[i].t_nvalid;
                push_request(req, dir_tab[i].typed, tres);
            end
        end

        while (n_random < RANDOM_ITEMS) begin
            start_phase();
            // first phase: output held off so the block backs up into its input
            if (n_settings == 1)
                rx_hold = HOLD_CYCLES;
            rush = (n_settings == 2);
            repeat ($urandom_range(30, 70)) begin
                push_request(random_request(), 1'b0, '0);
                n_random++;
            end
        end
        rush = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d results (%0d kept) from %0d loads and %0d evaluates",
                 n_results, n_kept, n_loads, n_evals);
        $display("%0d random register settings, one long output stall, one full-rate phase",
                 n_settings);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
